[rtl/dkgs_pkg.sv]
// shared types and constants of the depth key gap sorter
package dkgs_pkg;

   localparam int KEY_W       = 32;
   localparam int TAG_FIELD_W = 16;
   localparam int DATA_W      = KEY_W + TAG_FIELD_W;
   localparam int TDATA_W     = ((DATA_W + 7) / 8) * 8;

   typedef enum logic [6:0] {
      ST_LOAD      = 7'b0000001,
      ST_GAP       = 7'b0000010,
      ST_READ      = 7'b0000100,
      ST_CMP       = 7'b0001000,
      ST_SWAP      = 7'b0010000,
      ST_EMIT_RD   = 7'b0100000,
      ST_EMIT_DATA = 7'b1000000
   } state_type;

endpackage

[rtl/depth_key_gap_sorter_core.sv]
// depth key sorter: loads a set, shell-sorts it with halving gaps, streams it out in order
// loading takes one request per cycle; a compare-exchange reads a pair and compares it,
//   and on a swap writes both entries in turn through the single write port of the memory
// emission reads each result, then registers it out; a read waits on an untaken result
// throughput: one set at a time; the last result may wait while the next set loads
// reset: synchronous, clears the controller, counts and output valid; memory is not cleared
module depth_key_gap_sorter_core #(
   parameter int MAX_ITEMS = 64,
   parameter int TAG_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dkgs_pkg::TDATA_W-1:0] req_tdata,   // depth_key[31:0], item_tag[47:32]
   input  logic                        req_tlast,   // last_item
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dkgs_pkg::TDATA_W-1:0] rsp_tdata,   // sorted_key[31:0], sorted_tag[47:32]
   output logic                        rsp_tlast,   // end_of_set
   output logic                        rsp_tuser    // overflow
);
   import dkgs_pkg::*;

   localparam int TAG_W  = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
   localparam int REC_W  = KEY_W + TAG_W;
   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W  = CNT_W + 1;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  gap_ff, gap_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic              swap_seen_ff, swap_seen_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [REC_W-1:0]  rd_data_a;
   logic [REC_W-1:0]  rd_data_b;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [REC_W-1:0]  wr_data;

   logic              req_fire;
   logic              rsp_fire;
   logic [SUM_W-1:0]  pair_sum;
   logic [SUM_W-1:0]  next_sum;
   logic [ADDR_W-1:0] pair_idx;
   logic              more_pairs;
   logic              key_gt;
   logic              set_full;
   logic [CNT_W-1:0]  cnt_plus;
   logic              emit_last;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign pair_sum   = SUM_W'(idx_ff) + SUM_W'(gap_ff);
   assign next_sum   = pair_sum + SUM_W'(1);
   assign pair_idx   = pair_sum[ADDR_W-1:0];
   assign more_pairs = next_sum < SUM_W'(cnt_ff);
   assign key_gt     = $signed(rd_data_a[KEY_W-1:0]) > $signed(rd_data_b[KEY_W-1:0]);
   assign set_full   = cnt_ff >= CNT_W'(MAX_ITEMS);
   assign cnt_plus   = set_full ? cnt_ff : cnt_ff + CNT_W'(1);
   assign emit_last  = (SUM_W'(idx_ff) + SUM_W'(1)) == SUM_W'(cnt_ff);

   dkgs_store #(
      .DEPTH (MAX_ITEMS),
      .REC_W (REC_W)
   ) u_store (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      gap_in       = gap_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      swap_seen_in = swap_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_key_in   = rsp_key_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      rd_addr_a    = idx_ff;
      rd_addr_b    = pair_idx;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_b;

      case (state_ff)
         ST_LOAD: begin
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_data = {req_tdata[KEY_W +: TAG_W], req_tdata[KEY_W-1:0]};
            if (req_fire) begin
               wr_en  = !set_full;
               cnt_in = cnt_plus;
               if (set_full) begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  gap_in   = cnt_plus >> 1;
                  state_in = ST_GAP;
               end
            end
         end
         ST_GAP: begin
            idx_in       = '0;
            swap_seen_in = 1'b0;
            state_in     = (gap_ff == '0) ? ST_EMIT_RD : ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (key_gt) begin
               // lower entry takes the upper record now, upper entry next cycle
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = rd_data_b;
               state_in = ST_SWAP;
            end else if (more_pairs) begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_READ;
            end else if (swap_seen_ff) begin
               idx_in       = '0;
               swap_seen_in = 1'b0;
               state_in     = ST_READ;
            end else begin
               gap_in   = gap_ff >> 1;
               state_in = ST_GAP;
            end
         end
         ST_SWAP: begin
            wr_en   = 1'b1;
            wr_addr = pair_idx;
            wr_data = rd_data_a;
            if (more_pairs) begin
               idx_in       = idx_ff + ADDR_W'(1);
               swap_seen_in = 1'b1;
            end else begin
               // pass ended with an exchange: repeat at the same gap
               idx_in       = '0;
               swap_seen_in = 1'b0;
            end
            state_in = ST_READ;
         end
         ST_EMIT_RD: begin
            rd_addr_a = idx_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               rd_en    = 1'b1;
               state_in = ST_EMIT_DATA;
            end
         end
         ST_EMIT_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = rd_data_a[KEY_W-1:0];
            rsp_tag_in   = rd_data_a[KEY_W +: TAG_W];
            rsp_last_in  = emit_last;
            rsp_ovf_in   = ovf_ff;
            if (emit_last) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         gap_ff       <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         swap_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         gap_ff       <= gap_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         swap_seen_ff <= swap_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff  <= rsp_key_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({TAG_FIELD_W'(rsp_tag_ff), rsp_key_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // a new result only comes from a memory read of the emission step
   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EMIT_DATA))
      else $error("result raised outside emission");

   // sorting and emission always run on a nonempty set within capacity
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (cnt_ff != '0) && (cnt_ff <= CNT_W'(MAX_ITEMS)))
      else $error("record count out of range while busy");

   // the upper entry of a compared pair lies inside the set
   a_pair_in_set : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP || state_ff == ST_SWAP) |-> pair_sum < SUM_W'(cnt_ff))
      else $error("compare pair beyond record count");

   // emission never overwrites a result that is still waiting
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_DATA) |-> !rsp_valid_ff)
      else $error("output register overwritten");

endmodule

[rtl/dkgs_store.sv]
// record memory: one write port, two registered read ports
module dkgs_store #(
   parameter int DEPTH  = 64,
   parameter int REC_W  = 48,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [REC_W-1:0]  rd_data_a,
   output logic [REC_W-1:0]  rd_data_b,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [REC_W-1:0]  wr_data
);

   logic [REC_W-1:0] mem [DEPTH];
   logic [REC_W-1:0] rd_a_ff;
   logic [REC_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
